// ===== hdl/wfpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Worst-fit partition allocator package
// Shared types and fixed widths for the allocator controller and datapath.
// ----------------------------------------------------------------------------
package wfpa_pkg;

    localparam int SIZE_W  = 16;
    localparam int ID_W    = 16;
    localparam int TOTAL_W = 20;
    localparam int FRAG_W  = 19;
    localparam int PIDX_W  = 3;
    localparam int STAT_W  = 4;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 20'h80000;

    typedef enum logic [1:0] {
        CMD_DEFINE = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        RES_PLACED     = 4'd0,
        RES_DUPLICATE  = 4'd1,
        RES_BOTH_FRAG  = 4'd2,
        RES_INT_FRAG   = 4'd3,
        RES_EXT_FRAG   = 4'd4,
        RES_NO_SPACE   = 4'd5,
        RES_REMOVED    = 4'd6,
        RES_NOT_FOUND  = 4'd7,
        RES_DEFINED    = 4'd8,
        RES_REJECTED   = 4'd9,
        RES_TABLE_FULL = 4'd10
    } t_result;

    typedef enum logic [1:0] {
        SLOT_FREE     = 2'd0,
        SLOT_OCC      = 2'd1,
        SLOT_UNUSABLE = 2'd2
    } t_slot_st;

    // One partition table entry as stored in the slot memory.
    typedef struct packed {
        t_slot_st          st;
        logic [SIZE_W-1:0] size;
        logic [ID_W-1:0]   owner;
        logic [SIZE_W-1:0] occ;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic rd_en;
        logic commit;
    } t_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_cmd cmd;
        logic out_free;
    } t_sts;

endpackage

// ===== hdl/worst_fit_partition_allocator.sv =====
// ----------------------------------------------------------------------------
// Worst-fit partition allocator
// Fixed-partition memory allocator with worst-fit placement of processes.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake                  | Word
//  ---------+-----------+----------------------------+------------------------------
//  in       | input     | i_in_valid / o_in_stall    | command, proc_id, size_kb
//  out      | output    | o_out_valid / i_out_stall  | status, index, wasted, frag
//  cfg      | input     | i_cfg_valid / o_cfg_ready  | total_size
//
//  A define word goes from acceptance through dispatch straight to commit. An
//  insert or a delete scans the slot memory through its single read port, one
//  slot per cycle, and drains before it commits. A word with the unused command
//  code is taken and dropped. The next word is taken only once the block is
//  back in idle. Reset is synchronous and active low; the slot memory needs no
//  clearing pass because the defined-slot count marks which entries hold data.
//  A stalled result holds the commit of the next word.
//
module worst_fit_partition_allocator import wfpa_pkg::*; #(
    parameter int NUM_PARTITIONS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [TOTAL_W-1:0] i_cfg_total_size,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_command,
    input  logic [ID_W-1:0]    i_proc_id,
    input  logic [SIZE_W-1:0]  i_size_kb,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [STAT_W-1:0]  o_status,
    output logic [PIDX_W-1:0]  o_partition_index,
    output logic [TOTAL_W-1:0] o_wasted_space,
    output logic [FRAG_W-1:0]  o_internal_frag_total
);

    localparam int IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;

    t_ctl             w_ctl;
    t_sts             w_sts;
    logic [IDX_W-1:0] w_rd_addr;

    // The total size register can be written at any time the block is idle.
    assign o_cfg_ready = 1'b1;

    // The controller walks the state sequence and issues slot reads.
    wfpa_ctrl #(
        .NUM_PARTITIONS (NUM_PARTITIONS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl),
        .o_rd_addr  (w_rd_addr)
    );

    // The datapath owns the slot table, the running totals and the result.
    wfpa_datapath #(
        .NUM_PARTITIONS (NUM_PARTITIONS)
    ) u_datapath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_ctl                 (w_ctl),
        .i_rd_addr             (w_rd_addr),
        .o_sts                 (w_sts),
        .i_cfg_valid           (i_cfg_valid),
        .i_cfg_total_size      (i_cfg_total_size),
        .i_command             (i_command),
        .i_proc_id             (i_proc_id),
        .i_size_kb             (i_size_kb),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_status              (o_status),
        .o_partition_index     (o_partition_index),
        .o_wasted_space        (o_wasted_space),
        .o_internal_frag_total (o_internal_frag_total)
    );

    // A commit must never overwrite a result that is still waiting.
    a_commit_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.commit |-> !(o_out_valid && i_out_stall))
        else $error("commit while result word is stalled");

    // Every commit presents a result word in the following cycle.
    a_commit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.commit |=> o_out_valid)
        else $error("commit without result word");

    // Slot reads only happen while an accepted word is being processed.
    a_scan_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.rd_en |-> o_in_stall)
        else $error("slot scan while input channel open");

    // A full table or a failed lookup reports slot zero.
    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == RES_TABLE_FULL || o_status == RES_NOT_FOUND))
        |-> (o_partition_index == '0))
        else $error("nonzero index on a failed word");

endmodule

// ===== hdl/wfpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Worst-fit partition allocator controller
// Sequences one word: dispatch, scan and drain (insert/delete), commit.
// ----------------------------------------------------------------------------
module wfpa_ctrl import wfpa_pkg::*; #(
    parameter int NUM_PARTITIONS = 8,
    localparam int IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_sts             i_sts,
    output t_ctl             o_ctl,
    output logic [IDX_W-1:0] o_rd_addr
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_DRAIN,
        S_COMMIT
    } t_state;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PARTITIONS - 1);

    t_state           r_state;
    logic [IDX_W-1:0] r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    if (i_in_valid) begin
                        r_state <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    case (i_sts.cmd)
                        CMD_DEFINE: r_state <= S_COMMIT;
                        CMD_INSERT: r_state <= S_SCAN;
                        CMD_DELETE: r_state <= S_SCAN;
                        default:    r_state <= S_IDLE;
                    endcase
                end
                S_SCAN: begin
                    if (r_idx == LAST_IDX) begin
                        r_idx   <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_ctl.load   = (r_state == S_IDLE) && i_in_valid;
    assign o_ctl.rd_en  = (r_state == S_SCAN);
    assign o_ctl.commit = (r_state == S_COMMIT) && i_sts.out_free;
    assign o_rd_addr    = r_idx;

endmodule

// ===== hdl/wfpa_datapath.sv =====
// ----------------------------------------------------------------------------
// Worst-fit partition allocator datapath
// Slot memory, scan accumulators, allocation bookkeeping and result register.
// ----------------------------------------------------------------------------
module wfpa_datapath import wfpa_pkg::*; #(
    parameter int NUM_PARTITIONS = 8,
    localparam int IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1,
    localparam int CNT_W = $clog2(NUM_PARTITIONS + 1),
    localparam int SUM_W = SIZE_W + $clog2(NUM_PARTITIONS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctl               i_ctl,
    input  logic [IDX_W-1:0]   i_rd_addr,
    output t_sts               o_sts,
    input  logic               i_cfg_valid,
    input  logic [TOTAL_W-1:0] i_cfg_total_size,
    input  logic [1:0]         i_command,
    input  logic [ID_W-1:0]    i_proc_id,
    input  logic [SIZE_W-1:0]  i_size_kb,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [STAT_W-1:0]  o_status,
    output logic [PIDX_W-1:0]  o_partition_index,
    output logic [TOTAL_W-1:0] o_wasted_space,
    output logic [FRAG_W-1:0]  o_internal_frag_total
);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NUM_PARTITIONS);

    // Slot table. Entries at or above the defined count are never read as data.
    t_entry r_mem [NUM_PARTITIONS];
    t_entry r_rd_word;

    logic               r_eval;
    logic [IDX_W-1:0]   r_eval_idx;

    logic [TOTAL_W-1:0] r_total;
    logic [TOTAL_W-1:0] r_used, n_used;
    logic [CNT_W-1:0]   r_defined, n_defined;
    logic [FRAG_W-1:0]  r_frag, n_frag;

    t_cmd               r_cmd;
    logic [ID_W-1:0]    r_id;
    logic [SIZE_W-1:0]  r_sz;

    logic               r_dup_hit, n_dup_hit;
    logic [IDX_W-1:0]   r_dup_idx, n_dup_idx;
    logic [SIZE_W-1:0]  r_dup_size, n_dup_size;
    logic [SIZE_W-1:0]  r_dup_slack, n_dup_slack;
    logic               r_fit_hit, n_fit_hit;
    logic [IDX_W-1:0]   r_fit_idx, n_fit_idx;
    logic [SIZE_W-1:0]  r_fit_size, n_fit_size;
    logic [SIZE_W-1:0]  r_max_slack, n_max_slack;
    logic [SUM_W-1:0]   r_sum, n_sum;

    logic               r_out_valid;
    t_result            r_status, n_status;
    logic [PIDX_W-1:0]  r_pidx, n_pidx;
    logic [TOTAL_W-1:0] r_wasted, n_wasted;
    logic [FRAG_W-1:0]  r_frag_out;

    logic               w_wr_en;
    logic [IDX_W-1:0]   w_wr_addr;
    t_entry             w_wr_word;
    logic               w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    // Memory: one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_word;
        end
        if (i_ctl.rd_en) begin
            r_rd_word <= r_mem[i_rd_addr];
        end
    end

    // Scan accumulators, updated one slot per cycle behind the read.
    always_comb begin
        t_slot_st          v_st;
        logic [SIZE_W-1:0] v_slack;
        v_st    = (CNT_W'(r_eval_idx) < r_defined) ? r_rd_word.st : SLOT_UNUSABLE;
        v_slack = r_rd_word.size - r_rd_word.occ;

        n_dup_hit   = r_dup_hit;
        n_dup_idx   = r_dup_idx;
        n_dup_size  = r_dup_size;
        n_dup_slack = r_dup_slack;
        n_fit_hit   = r_fit_hit;
        n_fit_idx   = r_fit_idx;
        n_fit_size  = r_fit_size;
        n_max_slack = r_max_slack;
        n_sum       = r_sum;

        if (i_ctl.load) begin
            n_dup_hit   = 1'b0;
            n_fit_hit   = 1'b0;
            n_max_slack = '0;
            n_sum       = '0;
        end else if (r_eval) begin
            case (v_st)
                SLOT_OCC: begin
                    if (!r_dup_hit && r_rd_word.owner == r_id) begin
                        n_dup_hit   = 1'b1;
                        n_dup_idx   = r_eval_idx;
                        n_dup_size  = r_rd_word.size;
                        n_dup_slack = v_slack;
                    end
                    if (v_slack > r_max_slack) begin
                        n_max_slack = v_slack;
                    end
                    n_sum = r_sum + SUM_W'(v_slack);
                end
                SLOT_FREE: begin
                    if (!r_fit_hit && r_rd_word.size >= r_sz) begin
                        n_fit_hit  = 1'b1;
                        n_fit_idx  = r_eval_idx;
                        n_fit_size = r_rd_word.size;
                    end else if (r_fit_hit && r_fit_size < r_rd_word.size) begin
                        n_fit_idx  = r_eval_idx;
                        n_fit_size = r_rd_word.size;
                    end else begin
                        n_sum = r_sum + SUM_W'(r_rd_word.size);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Commit: table update, bookkeeping and the result word.
    always_comb begin
        logic [TOTAL_W:0] v_used_sum;
        v_used_sum = {1'b0, r_used} + (TOTAL_W + 1)'(r_sz);

        n_used    = r_used;
        n_defined = r_defined;
        n_frag    = r_frag;
        n_status  = RES_NOT_FOUND;
        n_pidx    = '0;
        w_wr_en   = 1'b0;
        w_wr_addr = IDX_W'(r_defined);
        w_wr_word = '{st: SLOT_FREE, size: r_sz, owner: '0, occ: '0};

        case (r_cmd)
            CMD_DEFINE: begin
                if (r_defined == FULL_CNT) begin
                    n_status = RES_TABLE_FULL;
                end else begin
                    n_defined = r_defined + 1'b1;
                    w_wr_en   = i_ctl.commit;
                    n_pidx    = PIDX_W'(r_defined);
                    if (v_used_sum > {1'b0, r_total}) begin
                        w_wr_word = '{st: SLOT_UNUSABLE, size: '0, owner: '0, occ: '0};
                        n_status  = RES_REJECTED;
                    end else begin
                        n_used   = v_used_sum[TOTAL_W-1:0];
                        n_status = RES_DEFINED;
                    end
                end
            end
            CMD_INSERT: begin
                if (r_dup_hit) begin
                    n_status = RES_DUPLICATE;
                    n_pidx   = PIDX_W'(r_dup_idx);
                end else if (r_fit_hit) begin
                    w_wr_en   = i_ctl.commit;
                    w_wr_addr = r_fit_idx;
                    w_wr_word = '{st: SLOT_OCC, size: r_fit_size, owner: r_id, occ: r_sz};
                    n_frag    = r_frag + FRAG_W'(r_fit_size - r_sz);
                    n_status  = RES_PLACED;
                    n_pidx    = PIDX_W'(r_fit_idx);
                end else if (SUM_W'(r_max_slack) >= SUM_W'(r_sz)
                             && r_sum >= SUM_W'(r_sz)) begin
                    n_status = RES_BOTH_FRAG;
                end else if (r_max_slack >= r_sz) begin
                    n_status = RES_INT_FRAG;
                end else if (r_sum >= SUM_W'(r_sz)) begin
                    n_status = RES_EXT_FRAG;
                end else begin
                    n_status = RES_NO_SPACE;
                end
            end
            CMD_DELETE: begin
                if (r_dup_hit) begin
                    w_wr_en   = i_ctl.commit;
                    w_wr_addr = r_dup_idx;
                    w_wr_word = '{st: SLOT_FREE, size: r_dup_size, owner: '0, occ: '0};
                    n_frag    = r_frag - FRAG_W'(r_dup_slack);
                    n_status  = RES_REMOVED;
                    n_pidx    = PIDX_W'(r_dup_idx);
                end
            end
            default: begin
            end
        endcase

        n_wasted = (r_total > n_used) ? (r_total - n_used) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= TOTAL_RESET;
            r_used      <= '0;
            r_defined   <= '0;
            r_frag      <= '0;
            r_eval      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_total <= i_cfg_total_size;
            end
            r_eval <= i_ctl.rd_en;
            if (i_ctl.commit) begin
                r_used      <= n_used;
                r_defined   <= n_defined;
                r_frag      <= n_frag;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_eval_idx  <= i_rd_addr;
        r_dup_hit   <= n_dup_hit;
        r_dup_idx   <= n_dup_idx;
        r_dup_size  <= n_dup_size;
        r_dup_slack <= n_dup_slack;
        r_fit_hit   <= n_fit_hit;
        r_fit_idx   <= n_fit_idx;
        r_fit_size  <= n_fit_size;
        r_max_slack <= n_max_slack;
        r_sum       <= n_sum;
        if (i_ctl.load) begin
            r_cmd <= t_cmd'(i_command);
            r_id  <= i_proc_id;
            r_sz  <= i_size_kb;
        end
        if (i_ctl.commit) begin
            r_status   <= n_status;
            r_pidx     <= n_pidx;
            r_wasted   <= n_wasted;
            r_frag_out <= n_frag;
        end
    end

    assign o_sts.cmd             = r_cmd;
    assign o_sts.out_free        = w_out_free;
    assign o_out_valid           = r_out_valid;
    assign o_status              = r_status;
    assign o_partition_index     = r_pidx;
    assign o_wasted_space        = r_wasted;
    assign o_internal_frag_total = r_frag_out;

endmodule

// ===== test/worst_fit_partition_allocator_checker.sv =====
// ----------------------------------------------------------------------------
// Worst-fit partition allocator checker
// Watches the word, result and total-size channels of the allocator, keeps
// its own copy of the partition table and checks each result in order.
// ----------------------------------------------------------------------------
module worst_fit_partition_allocator_checker import wfpa_pkg::*; #(
    parameter int NUM_PARTITIONS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [TOTAL_W-1:0] i_cfg_total_size,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_command,
    input  logic [ID_W-1:0]    i_proc_id,
    input  logic [SIZE_W-1:0]  i_size_kb,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [STAT_W-1:0]  i_status,
    input  logic [PIDX_W-1:0]  i_partition_index,
    input  logic [TOTAL_W-1:0] i_wasted_space,
    input  logic [FRAG_W-1:0]  i_internal_frag_total,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_result            status;
        logic [PIDX_W-1:0]  pidx;
        logic [TOTAL_W-1:0] wasted;
        logic [FRAG_W-1:0]  frag;
    } t_alloc_reply;

    t_alloc_reply       replies_due[$];
    t_slot_st           slot_st    [NUM_PARTITIONS];
    logic [SIZE_W-1:0]  slot_sz    [NUM_PARTITIONS];
    logic [ID_W-1:0]    slot_owner [NUM_PARTITIONS];
    logic [SIZE_W-1:0]  occ_sz     [NUM_PARTITIONS];
    int unsigned        used_kb;
    int                 slots_made;
    logic [TOTAL_W-1:0] total_kb;

    initial o_fail_count = 0;
    initial o_pending = 0;

    function automatic t_alloc_reply reply_for(t_result res, int slot);
        t_alloc_reply r;
        int unsigned  frag_sum;
        frag_sum = 0;
        for (int i = 0; i < NUM_PARTITIONS; i++) begin
            if (slot_st[i] == SLOT_OCC)
                frag_sum += slot_sz[i] - occ_sz[i];
        end
        r.status = res;
        r.pidx   = PIDX_W'(slot);
        r.wasted = (total_kb > used_kb) ? TOTAL_W'(total_kb - used_kb) : '0;
        r.frag   = FRAG_W'(frag_sum);
        return r;
    endfunction

    // Only occupied slots carry a valid owner.
    function automatic int owner_slot(logic [ID_W-1:0] id);
        for (int i = 0; i < NUM_PARTITIONS; i++) begin
            if (slot_st[i] == SLOT_OCC && slot_owner[i] == id)
                return i;
        end
        return -1;
    endfunction

    function automatic void allocate_word(t_cmd cmd, logic [ID_W-1:0] id,
                                          logic [SIZE_W-1:0] sz);
        int          slot;
        int          fit;
        int unsigned max_slack;
        int unsigned sum_space;
        int unsigned slack;
        t_result     res;
        case (cmd)
            CMD_DEFINE: begin
                if (slots_made >= NUM_PARTITIONS) begin
                    replies_due.push_back(reply_for(RES_TABLE_FULL, 0));
                end else begin
                    slot = slots_made;
                    slots_made++;
                    occ_sz[slot] = '0;
                    if (used_kb + sz > total_kb) begin
                        slot_st[slot] = SLOT_UNUSABLE;
                        slot_sz[slot] = '0;
                        replies_due.push_back(reply_for(RES_REJECTED, slot));
                    end else begin
                        used_kb += sz;
                        slot_st[slot] = SLOT_FREE;
                        slot_sz[slot] = sz;
                        replies_due.push_back(reply_for(RES_DEFINED, slot));
                    end
                end
            end
            CMD_INSERT: begin
                slot = owner_slot(id);
                if (slot >= 0) begin
                    replies_due.push_back(reply_for(RES_DUPLICATE, slot));
                end else begin
                    fit = -1;
                    max_slack = 0;
                    sum_space = 0;
                    for (int i = 0; i < NUM_PARTITIONS; i++) begin
                        if (slot_st[i] == SLOT_UNUSABLE)
                            continue;
                        if (slot_st[i] == SLOT_OCC) begin
                            slack = slot_sz[i] - occ_sz[i];
                            if (slack > max_slack)
                                max_slack = slack;
                            sum_space += slack;
                            continue;
                        end
                        if (fit < 0 && slot_sz[i] >= sz)
                            fit = i;
                        else if (fit >= 0 && slot_sz[fit] < slot_sz[i])
                            fit = i;
                        else
                            sum_space += slot_sz[i];
                    end
                    if (fit < 0) begin
                        if (max_slack >= sz && sum_space >= sz)
                            res = RES_BOTH_FRAG;
                        else if (max_slack >= sz)
                            res = RES_INT_FRAG;
                        else if (sum_space >= sz)
                            res = RES_EXT_FRAG;
                        else
                            res = RES_NO_SPACE;
                        replies_due.push_back(reply_for(res, 0));
                    end else begin
                        slot_st[fit] = SLOT_OCC;
                        slot_owner[fit] = id;
                        occ_sz[fit] = sz;
                        replies_due.push_back(reply_for(RES_PLACED, fit));
                    end
                end
            end
            CMD_DELETE: begin
                slot = owner_slot(id);
                if (slot < 0) begin
                    replies_due.push_back(reply_for(RES_NOT_FOUND, 0));
                end else begin
                    slot_st[slot] = SLOT_FREE;
                    slot_owner[slot] = '0;
                    occ_sz[slot] = '0;
                    replies_due.push_back(reply_for(RES_REMOVED, slot));
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_alloc_reply want;
        if (!i_rst_n) begin
            replies_due.delete();
            for (int i = 0; i < NUM_PARTITIONS; i++) begin
                slot_st[i] = SLOT_UNUSABLE;
                slot_sz[i] = '0;
                slot_owner[i] = '0;
                occ_sz[i] = '0;
            end
            used_kb = 0;
            slots_made = 0;
            total_kb = TOTAL_RESET;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                total_kb = i_cfg_total_size;
            if (i_out_valid && !i_out_stall) begin
                if (replies_due.size() == 0) begin
                    $display("%0t: result with no word outstanding, expected none, actual status %0d",
                             $time, i_status);
                    o_fail_count++;
                end else begin
                    want = replies_due.pop_front();
                    check_field("status", want.status, i_status);
                    check_field("partition_index", want.pidx, i_partition_index);
                    check_field("wasted_space", want.wasted, i_wasted_space);
                    check_field("internal_frag_total", want.frag, i_internal_frag_total);
                end
            end
            if (i_in_valid && !i_in_stall)
                allocate_word(t_cmd'(i_command), i_proc_id, i_size_kb);
        end
        o_pending = replies_due.size();
    end

endmodule

// ===== test/worst_fit_partition_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// Worst-fit partition allocator testbench
// Drives directed and random command words into the allocator with random
// idling on both channels and a checker that predicts every result.
// ----------------------------------------------------------------------------
module worst_fit_partition_allocator_tb import wfpa_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PARTITIONS  = 8;
    // Longest block latency is a full slot scan; give it some margin when
    // waiting for the block to go quiet.
    localparam int SETTLE_CYCLES   = 2 * NUM_PARTITIONS + 8;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int PHASES          = 5;
    localparam int PHASE_WORDS     = 110;
    localparam int RUN_LIMIT_NS    = 300_000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [TOTAL_W-1:0] i_cfg_total_size;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_command;
    logic [ID_W-1:0]    i_proc_id;
    logic [SIZE_W-1:0]  i_size_kb;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [STAT_W-1:0]  o_status;
    logic [PIDX_W-1:0]  o_partition_index;
    logic [TOTAL_W-1:0] o_wasted_space;
    logic [FRAG_W-1:0]  o_internal_frag_total;

    int alloc_fails;
    int alloc_pending;

    // State for the word sender and the result receiver.
    bit calm_tail = 1'b0;     // no idling on either side in the last phase
    bit hold_off_req = 1'b0;  // receiver holds off for a long stretch
    int sender_calm = 0;      // words left in a stretch without gaps

    worst_fit_partition_allocator #(
        .NUM_PARTITIONS(NUM_PARTITIONS)
    ) i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_total_size     (i_cfg_total_size),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_command            (i_command),
        .i_proc_id            (i_proc_id),
        .i_size_kb            (i_size_kb),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_status             (o_status),
        .o_partition_index    (o_partition_index),
        .o_wasted_space       (o_wasted_space),
        .o_internal_frag_total(o_internal_frag_total)
    );

    worst_fit_partition_allocator_checker #(
        .NUM_PARTITIONS(NUM_PARTITIONS)
    ) i_checker (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_ready          (o_cfg_ready),
        .i_cfg_total_size     (i_cfg_total_size),
        .i_in_valid           (i_in_valid),
        .i_in_stall           (o_in_stall),
        .i_command            (i_command),
        .i_proc_id            (i_proc_id),
        .i_size_kb            (i_size_kb),
        .i_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .i_status             (o_status),
        .i_partition_index    (o_partition_index),
        .i_wasted_space       (o_wasted_space),
        .i_internal_frag_total(o_internal_frag_total),
        .o_fail_count         (alloc_fails),
        .o_pending            (alloc_pending)
    );

    // 2 ns clock.
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Hard limit on the run, far above the slowest legal run.
    initial begin
        #RUN_LIMIT_NS;
        $display("end of test: mismatches");
        $finish;
    end

    // Result receiver. Mostly takes every result, sometimes stalls for a
    // random burst, sometimes runs a long stretch without stalling, and on
    // request holds off long enough that the block backs up into its input.
    initial begin
        int burst;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                i_out_stall <= 1'b1;
                for (int c = 0; c < HOLD_OFF_CYCLES; c++)
                    @(posedge i_clk);
                hold_off_req = 1'b0;
                i_out_stall <= 1'b0;
            end else if (calm_tail) begin
                i_out_stall <= 1'b0;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        burst = $urandom_range(1, 14);
                        i_out_stall <= 1'b1;
                        repeat (burst) @(posedge i_clk);
                        i_out_stall <= 1'b0;
                    end
                    2: begin
                        i_out_stall <= 1'b0;
                        repeat ($urandom_range(20, 60)) @(posedge i_clk);
                    end
                    default: i_out_stall <= 1'b0;
                endcase
            end
        end
    end

    // Offers one word and holds it until the block takes it. Valid stays
    // high afterwards so back-to-back words need no extra edge; anything
    // that waits between words must lower it first.
    task automatic send_word(t_cmd cmd, logic [ID_W-1:0] id, logic [SIZE_W-1:0] sz);
        int gap;
        if (sender_calm > 0) begin
            sender_calm--;
        end else if (!calm_tail) begin
            case ($urandom_range(0, 7))
                0, 1: begin
                    gap = $urandom_range(1, 14);
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                2: sender_calm = $urandom_range(15, 40);
                default: ;
            endcase
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_proc_id    <= id;
        i_size_kb    <= sz;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Stops offering words and waits until every result has come back, then
    // lets the block finish any word that produces no result.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait (alloc_pending == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Only called while the block is idle.
    task automatic write_total(logic [TOTAL_W-1:0] value);
        i_cfg_valid      <= 1'b1;
        i_cfg_total_size <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random word. A small pool of process ids keeps duplicates, finds and
    // removals frequent; sizes lean toward values that fit the partitions.
    // Returns 0 for the unused command, which produces no result.
    task automatic send_random_word(output bit counted);
        int                r;
        t_cmd              cmd;
        logic [ID_W-1:0]   id;
        logic [SIZE_W-1:0] sz;
        r = $urandom_range(0, 99);
        if (r < 4)
            cmd = CMD_DEFINE;
        else if (r < 8)
            cmd = CMD_UNUSED;
        else if (r < 55)
            cmd = CMD_INSERT;
        else
            cmd = CMD_DELETE;
        if ($urandom_range(0, 9) == 0)
            id = ID_W'($urandom_range(0, 16'hFFFF));
        else
            id = ID_W'($urandom_range(0, 11));
        case ($urandom_range(0, 4))
            0: sz = SIZE_W'($urandom_range(0, 16'hFFFF));
            1: sz = SIZE_W'($urandom_range(0, 1000));
            2: sz = SIZE_W'($urandom_range(0, 25000));
            3: sz = SIZE_W'($urandom_range(0, 45000));
            default: sz = $urandom_range(0, 1) ? '1 : '0;
        endcase
        send_word(cmd, id, sz);
        counted = (cmd != CMD_UNUSED);
    endtask

    initial begin
        logic [TOTAL_W-1:0] total;
        int                 sent;
        bit                 counted;

        i_rst_n          = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_total_size = '0;
        i_in_valid       = 1'b0;
        i_command        = CMD_DEFINE;
        i_proc_id        = '0;
        i_size_kb        = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table: a zero-size insert finds nothing usable and counts as
        // both kinds of fragmentation, a delete finds nothing, and the unused
        // command is dropped without a result.
        send_word(CMD_INSERT, 16'h0042, 16'd0);
        send_word(CMD_DELETE, 16'h0042, 16'd0);
        send_word(CMD_UNUSED, 16'hFFFF, 16'hFFFF);
        drain_results();

        // Build the table against a 200000 KB total: slot 4 overflows and is
        // rejected, slot 6 lands exactly on the total, slot 7 is one over,
        // and a ninth define finds the table full.
        write_total(20'd200000);
        send_word(CMD_DEFINE, 16'd0, 16'd65535);
        send_word(CMD_DEFINE, 16'd0, 16'd0);
        send_word(CMD_DEFINE, 16'd0, 16'd40000);
        send_word(CMD_DEFINE, 16'd0, 16'd65535);
        send_word(CMD_DEFINE, 16'd0, 16'd65535);
        send_word(CMD_DEFINE, 16'd0, 16'd20000);
        send_word(CMD_DEFINE, 16'd0, 16'd8930);
        send_word(CMD_DEFINE, 16'd0, 16'd1);
        send_word(CMD_DEFINE, 16'd0, 16'd7);

        // Placement: the two largest partitions tie and the earlier wins,
        // then a duplicate id, a near-full fit, an exact fit, external
        // fragmentation, no space at all, a zero-size word taking the largest
        // free slot, and both kinds of fragmentation.
        send_word(CMD_INSERT, 16'hFFFF, 16'd65535);
        send_word(CMD_INSERT, 16'hFFFF, 16'd1);
        send_word(CMD_INSERT, 16'h0000, 16'd65000);
        send_word(CMD_INSERT, 16'h0001, 16'd40000);
        send_word(CMD_INSERT, 16'h0002, 16'd25000);
        send_word(CMD_INSERT, 16'h0003, 16'd30000);
        send_word(CMD_INSERT, 16'h0004, 16'd0);
        send_word(CMD_INSERT, 16'h0009, 16'd10000);

        // Removal, then the same id again: the freed slot keeps no owner.
        send_word(CMD_DELETE, 16'h1234, 16'd0);
        send_word(CMD_DELETE, 16'h0004, 16'd0);
        send_word(CMD_DELETE, 16'h0004, 16'd0);
        send_word(CMD_DELETE, 16'hFFFF, 16'hFFFF);
        drain_results();

        // Random phases, each under its own total size. Lowering the total
        // under the space already given out makes the wasted space saturate.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: total = TOTAL_RESET;
                1: total = '0;
                2: total = TOTAL_W'($urandom_range(0, 20'h7FFFF));
                3: total = 20'd199999;
                default: total = TOTAL_W'($urandom_range(200000, 524288));
            endcase
            write_total(total);
            if (phase == 0)
                hold_off_req = 1'b1;
            if (phase == PHASES - 1)
                calm_tail = 1'b1;
            sent = 0;
            while (sent < PHASE_WORDS) begin
                send_random_word(counted);
                if (counted)
                    sent++;
                // One pause in the middle of a phase until the block is empty.
                if (phase == 2 && sent == PHASE_WORDS / 2 && counted)
                    drain_results();
            end
            drain_results();
        end

        if (alloc_fails == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
